>>> sv/dcc_enc_pkg.sv
// Shared types and constants for the DCC packet symbol encoder.
// No dependencies; imported by every module of the block.
package dcc_enc_pkg;

   localparam int unsigned TICK_W = 15;
   localparam int unsigned PRE_W  = 6;

   // Preamble length limit, cutout length and index of the last data bit.
   localparam logic [PRE_W-1:0] MAX_PREAMBLE   = 6'd48;
   localparam logic [PRE_W-1:0] CUTOUT_SYMBOLS = 6'd4;
   localparam logic [PRE_W-1:0] DATA_LAST_BIT  = 6'd7;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ONE_BIT_TICKS  = 3'd0;
   localparam logic [2:0] CSR_ZERO_BIT_TICKS = 3'd1;
   localparam logic [2:0] CSR_END_BIT_TICKS  = 3'd2;
   localparam logic [2:0] CSR_CUTOUT_TICKS   = 3'd3;
   localparam logic [2:0] CSR_CUTOUT_ENABLE  = 3'd4;
   localparam logic [2:0] CSR_LEAD_ZERO_EN   = 3'd5;
   localparam logic [2:0] CSR_FIRST_LEVEL    = 3'd6;
   localparam logic [2:0] CSR_PREAMBLE_COUNT = 3'd7;

   typedef struct packed {
      logic [TICK_W-1:0] one_bit_ticks;
      logic [TICK_W-1:0] zero_bit_ticks;
      logic [TICK_W-1:0] end_bit_ticks;
      logic [TICK_W-1:0] cutout_ticks;
      logic              cutout_enable;
      logic              leading_zero_enable;
      logic              first_half_level;
      logic [PRE_W-1:0]  preamble_count;
   } cfg_type;

   typedef enum logic [1:0] {
      SYM_CUT,
      SYM_ZERO,
      SYM_ONE,
      SYM_END
   } sym_kind_type;

   typedef struct packed {
      sym_kind_type kind;
      logic         run_last;
      logic         done;
   } sym_type;

endpackage

>>> sv/dcc_enc_seq.sv
// Symbol sequencer: walks cutout, leading zero, preamble, start, data and end phases.
// Depends on dcc_enc_pkg.
module dcc_enc_seq
   import dcc_enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] packet_byte,
   input  logic       last_byte,
   input  logic       slot_free,
   output logic       sym_valid,
   output sym_type    sym
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CUT,
      PH_LEAD,
      PH_PRE,
      PH_START,
      PH_DATA,
      PH_END
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [PRE_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             in_packet_ff, in_packet_in;

   logic [PRE_W-1:0] pre_len;
   logic             cut_on;
   logic             step_en;
   logic             accept;
   phase_type        after_lead;
   phase_type        after_cut;
   phase_type        first_phase;

   assign cut_on  = cfg.cutout_enable && (cfg.cutout_ticks != '0);
   assign pre_len = (cfg.preamble_count > MAX_PREAMBLE) ? MAX_PREAMBLE : cfg.preamble_count;

   assign after_lead  = (pre_len != '0) ? PH_PRE : PH_START;
   assign after_cut   = cfg.leading_zero_enable ? PH_LEAD : after_lead;
   assign first_phase = in_packet_ff ? PH_START : (cut_on ? PH_CUT : after_cut);

   assign req_tready = (phase_ff == PH_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sym_valid  = (phase_ff != PH_IDLE);
   assign step_en    = sym_valid && slot_free;

   always_comb begin
      sym.kind     = SYM_ZERO;
      sym.run_last = 1'b0;
      sym.done     = 1'b0;
      unique case (phase_ff)
         PH_IDLE:  sym.kind = SYM_ZERO;
         PH_CUT:   sym.kind = SYM_CUT;
         PH_LEAD:  sym.kind = SYM_ZERO;
         PH_PRE:   sym.kind = SYM_ONE;
         PH_START: sym.kind = SYM_ZERO;
         PH_DATA: begin
            sym.kind     = byte_ff[7] ? SYM_ONE : SYM_ZERO;
            sym.run_last = (cnt_ff == DATA_LAST_BIT) && !last_ff;
         end
         PH_END: begin
            sym.kind     = SYM_END;
            sym.run_last = 1'b1;
            sym.done     = 1'b1;
         end
         default: sym.kind = SYM_ZERO;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      in_packet_in = in_packet_ff;
      if (accept) begin
         phase_in     = first_phase;
         cnt_in       = '0;
         byte_in      = packet_byte;
         last_in      = last_byte;
         in_packet_in = !last_byte;
      end else if (step_en) begin
         unique case (phase_ff)
            PH_CUT: begin
               if (cnt_ff == CUTOUT_SYMBOLS - 6'd1) begin
                  phase_in = after_cut;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
            PH_LEAD: begin
               phase_in = after_lead;
               cnt_in   = '0;
            end
            PH_PRE: begin
               if (cnt_ff == pre_len - 6'd1) begin
                  phase_in = PH_START;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
            PH_START: begin
               phase_in = PH_DATA;
               cnt_in   = '0;
            end
            PH_DATA: begin
               byte_in = {byte_ff[6:0], 1'b0};
               if (cnt_ff == DATA_LAST_BIT) begin
                  phase_in = last_ff ? PH_END : PH_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
            PH_END:  phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         in_packet_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         in_packet_ff <= in_packet_in;
         last_ff      <= last_in;
      end
      byte_ff <= byte_in;
   end

   // The final symbol of an item returns the sequencer to idle.
   a_run_last_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && sym.run_last |=> phase_ff == PH_IDLE)
      else $error("sequencer busy after last symbol of item");

   // End symbol only on the last byte of a packet.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      sym_valid && sym.done |-> last_ff)
      else $error("end symbol on a byte not flagged last");

   // Preamble count stays inside the clamped length.
   a_pre_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PRE |-> cnt_ff < pre_len)
      else $error("preamble counter overran");

   // Cutout count stays inside the cutout length.
   a_cut_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CUT |-> cnt_ff < CUTOUT_SYMBOLS)
      else $error("cutout counter overran");

endmodule

>>> sv/dcc_enc_fmt.sv
// Symbol formatter: maps a symbol kind to durations and levels into the output register.
// Depends on dcc_enc_pkg.
module dcc_enc_fmt
   import dcc_enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        sym_valid,
   input  sym_type     sym,
   output logic        slot_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tuser
);

   logic              valid_ff;
   logic [31:0]       data_ff, data_in;
   logic              last_ff;
   logic              done_ff;
   logic [TICK_W-1:0] first_dur;
   logic [TICK_W-1:0] second_dur;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      unique case (sym.kind)
         SYM_CUT: begin
            first_dur  = cfg.cutout_ticks;
            second_dur = cfg.cutout_ticks;
         end
         SYM_ZERO: begin
            first_dur  = cfg.zero_bit_ticks;
            second_dur = cfg.zero_bit_ticks;
         end
         SYM_ONE: begin
            first_dur  = cfg.one_bit_ticks;
            second_dur = cfg.one_bit_ticks;
         end
         SYM_END: begin
            first_dur  = cfg.one_bit_ticks;
            second_dur = (cfg.end_bit_ticks != '0) ? cfg.end_bit_ticks : cfg.one_bit_ticks;
         end
         default: begin
            first_dur  = cfg.one_bit_ticks;
            second_dur = cfg.one_bit_ticks;
         end
      endcase
   end

   assign data_in = {!cfg.first_half_level, second_dur, cfg.first_half_level, first_dur};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (slot_free) begin
         valid_ff <= sym_valid;
      end
      if (slot_free && sym_valid) begin
         data_ff <= data_in;
         last_ff <= sym.run_last;
         done_ff <= sym.done;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

>>> sv/dcc_packet_symbol_encoder_core.sv
// DCC packet symbol encoder, top level: configuration registers, sequencer, formatter.
// The sequencer registers each accepted byte; the formatter registers each symbol.
// No new item is taken until every symbol of the last one has been stepped out; an item
// produces N symbols, N being 9 or 10 for later bytes and 9 or 10 plus the clamped
// preamble (+1 leading zero, +4 cutout) for the first byte of a packet.
// Reset (synchronous, active high) loads register defaults and awaits a first byte.
module dcc_packet_symbol_encoder_core
   import dcc_enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Item input: tdata = packet_byte[7:0]; tlast = last_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] packet_byte
   input  logic        req_tlast,
   // Symbol output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [14:0] first_duration, [15] first_level,
                                     // [30:16] second_duration, [31] second_level
   output logic        rsp_tlast,    // run_last
   output logic        rsp_tuser,    // [0] packet_done
   // Configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [14:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    slot_free;
   logic    sym_valid;
   sym_type sym;

   // Hold configuration; the user must write only while the block is idle, not enforced here.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_bit_ticks       <= 15'd58;
         cfg_ff.zero_bit_ticks      <= 15'd100;
         cfg_ff.end_bit_ticks       <= '0;
         cfg_ff.cutout_ticks        <= '0;
         cfg_ff.cutout_enable       <= 1'b0;
         cfg_ff.leading_zero_enable <= 1'b0;
         cfg_ff.first_half_level    <= 1'b1;
         cfg_ff.preamble_count      <= 6'd17;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ONE_BIT_TICKS:  cfg_ff.one_bit_ticks       <= csr_wdata;
            CSR_ZERO_BIT_TICKS: cfg_ff.zero_bit_ticks      <= csr_wdata;
            CSR_END_BIT_TICKS:  cfg_ff.end_bit_ticks       <= csr_wdata;
            CSR_CUTOUT_TICKS:   cfg_ff.cutout_ticks        <= csr_wdata;
            CSR_CUTOUT_ENABLE:  cfg_ff.cutout_enable       <= csr_wdata[0];
            CSR_LEAD_ZERO_EN:   cfg_ff.leading_zero_enable <= csr_wdata[0];
            CSR_FIRST_LEVEL:    cfg_ff.first_half_level    <= csr_wdata[0];
            CSR_PREAMBLE_COUNT: cfg_ff.preamble_count      <= csr_wdata[PRE_W-1:0];
            default:            cfg_ff.one_bit_ticks       <= cfg_ff.one_bit_ticks;
         endcase
      end
   end

   // Advance one symbol per cycle while the output register has room.
   dcc_enc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .packet_byte (req_tdata),
      .last_byte   (req_tlast),
      .slot_free   (slot_free),
      .sym_valid   (sym_valid),
      .sym         (sym)
   );

   // Turn each symbol into durations and levels and hold it until taken.
   dcc_enc_fmt u_fmt (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .sym_valid  (sym_valid),
      .sym        (sym),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> sim/dcc_line_symbol_checker.sv
`timescale 1ns / 100ps
// Self-checking monitor for the DCC packet symbol encoder: mirrors the register file,
// predicts line symbols per accepted byte and compares them. Depends on dcc_enc_pkg.
module dcc_line_symbol_checker
   import dcc_enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [14:0] csr_wdata,
   output int          symbols_due,
   output int          mismatches
);

   localparam int MAX_SYMBOLS   = 64;
   localparam int FIXED_SYMBOLS = 11;

   typedef struct packed {
      logic [TICK_W-1:0] first_duration;
      logic              first_level;
      logic [TICK_W-1:0] second_duration;
      logic              second_level;
      logic              run_last;
      logic              packet_done;
   } line_symbol_type;

   cfg_type         regs;
   logic            mid_packet;
   line_symbol_type symbols_q[$];

   function automatic line_symbol_type make_symbol(input logic [TICK_W-1:0] first_ticks,
                                                    input logic [TICK_W-1:0] second_ticks,
                                                    input logic done);
      line_symbol_type s;
      s.first_duration  = first_ticks;
      s.first_level     = regs.first_half_level;
      s.second_duration = second_ticks;
      s.second_level    = ~regs.first_half_level;
      s.run_last        = 1'b0;
      s.packet_done     = done;
      return s;
   endfunction

   task automatic encode_byte(input logic [7:0] data, input logic last);
      int              room;
      int              preamble;
      int              bit_idx;
      logic            cut;
      logic [TICK_W-1:0] ticks;
      line_symbol_type tail;
      if (!mid_packet) begin
         cut = regs.cutout_enable && (regs.cutout_ticks != '0);
         room = MAX_SYMBOLS - FIXED_SYMBOLS - (cut ? int'(CUTOUT_SYMBOLS) : 0);
         preamble = int'(regs.preamble_count);
         if (preamble > int'(MAX_PREAMBLE)) preamble = int'(MAX_PREAMBLE);
         if (preamble > room) preamble = room;
         if (cut)
            repeat (CUTOUT_SYMBOLS)
               symbols_q.push_back(make_symbol(regs.cutout_ticks, regs.cutout_ticks, 1'b0));
         if (regs.leading_zero_enable)
            symbols_q.push_back(make_symbol(regs.zero_bit_ticks, regs.zero_bit_ticks, 1'b0));
         repeat (preamble)
            symbols_q.push_back(make_symbol(regs.one_bit_ticks, regs.one_bit_ticks, 1'b0));
      end
      // start zero on a first byte, separator zero otherwise
      symbols_q.push_back(make_symbol(regs.zero_bit_ticks, regs.zero_bit_ticks, 1'b0));
      for (bit_idx = int'(DATA_LAST_BIT); bit_idx >= 0; bit_idx--) begin
         ticks = data[bit_idx] ? regs.one_bit_ticks : regs.zero_bit_ticks;
         symbols_q.push_back(make_symbol(ticks, ticks, 1'b0));
      end
      if (last) begin
         ticks = (regs.end_bit_ticks != '0) ? regs.end_bit_ticks : regs.one_bit_ticks;
         symbols_q.push_back(make_symbol(regs.one_bit_ticks, ticks, 1'b1));
      end
      mid_packet = !last;
      tail = symbols_q.pop_back();
      tail.run_last = 1'b1;
      symbols_q.push_back(tail);
   endtask

   always @(posedge clock) begin : watch
      line_symbol_type got;
      line_symbol_type want;
      if (reset) begin
         regs = '{one_bit_ticks: 15'd58, zero_bit_ticks: 15'd100, end_bit_ticks: 15'd0,
                  cutout_ticks: 15'd0, cutout_enable: 1'b0, leading_zero_enable: 1'b0,
                  first_half_level: 1'b1, preamble_count: 6'd17};
         mid_packet = 1'b0;
         symbols_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_ONE_BIT_TICKS:  regs.one_bit_ticks       = csr_wdata;
               CSR_ZERO_BIT_TICKS: regs.zero_bit_ticks      = csr_wdata;
               CSR_END_BIT_TICKS:  regs.end_bit_ticks       = csr_wdata;
               CSR_CUTOUT_TICKS:   regs.cutout_ticks        = csr_wdata;
               CSR_CUTOUT_ENABLE:  regs.cutout_enable       = csr_wdata[0];
               CSR_LEAD_ZERO_EN:   regs.leading_zero_enable = csr_wdata[0];
               CSR_FIRST_LEVEL:    regs.first_half_level    = csr_wdata[0];
               CSR_PREAMBLE_COUNT: regs.preamble_count      = csr_wdata[PRE_W-1:0];
               default: ;
            endcase
         end
         // queue the new byte first: a symbol leaving now is never from a later byte
         if (req_tvalid && req_tready)
            encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[14:0], rsp_tdata[15], rsp_tdata[30:16], rsp_tdata[31],
                    rsp_tlast, rsp_tuser};
            if (symbols_q.size() == 0) begin
               $error("unexpected symbol: tdata %h tlast %b tuser %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = symbols_q.pop_front();
               if (got.first_duration !== want.first_duration) begin
                  $error("first_duration: expected %0d, got %0d",
                         want.first_duration, got.first_duration);
                  mismatches++;
               end
               if (got.first_level !== want.first_level) begin
                  $error("first_level: expected %0d, got %0d",
                         want.first_level, got.first_level);
                  mismatches++;
               end
               if (got.second_duration !== want.second_duration) begin
                  $error("second_duration: expected %0d, got %0d",
                         want.second_duration, got.second_duration);
                  mismatches++;
               end
               if (got.second_level !== want.second_level) begin
                  $error("second_level: expected %0d, got %0d",
                         want.second_level, got.second_level);
                  mismatches++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
                  mismatches++;
               end
               if (got.packet_done !== want.packet_done) begin
                  $error("packet_done: expected %0d, got %0d",
                         want.packet_done, got.packet_done);
                  mismatches++;
               end
            end
         end
      end
      symbols_due = symbols_q.size();
   end

endmodule

>>> sim/dcc_packet_symbol_encoder_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the DCC packet symbol encoder: clock, reset, byte and register stimulus
// and the verdict. Depends on dcc_enc_pkg, the encoder core and dcc_line_symbol_checker.
module dcc_packet_symbol_encoder_core_test
   import dcc_enc_pkg::*;
();

   // Generous ceiling: even a run of longest packets with heavy stalls ends far below it.
   localparam int CYCLE_LIMIT    = 400000;
   // Settle time after the last symbol, with margin.
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 33;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [14:0] csr_wdata;

   int   symbols_due;
   int   mismatches;
   int   cycles;
   logic calm;   // no idling on either side while set

   dcc_packet_symbol_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dcc_line_symbol_checker symbol_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .symbols_due (symbols_due),
      .mismatches  (mismatches)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver: stall in roughly a quarter of the cycles unless the calm stretch is on.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 24);
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one byte, with an optional random gap in front, and hold it until accepted.
   // Returns just after the accepting edge with valid still high.
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = (!calm && $urandom_range(99) < 24) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_packet(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   // Drop valid and hold off until every predicted symbol has left the block.
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (symbols_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Single-cycle register write; only called while the block is idle.
   task automatic write_reg(input logic [2:0] addr, input logic [14:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [14:0] pick_ticks();
      case ($urandom_range(9))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'd1;
         default: return 15'($urandom_range(1, 32767));
      endcase
   endfunction

   // Fresh random setting of every register; mostly short preambles to keep runs brisk.
   task automatic randomise_regs;
      logic [14:0] preamble;
      case ($urandom_range(7))
         0:       preamble = 15'd48;
         1:       preamble = 15'd63;
         2:       preamble = 15'd0;
         default: preamble = 15'($urandom_range(1, 20));
      endcase
      write_reg(CSR_ONE_BIT_TICKS, pick_ticks());
      write_reg(CSR_ZERO_BIT_TICKS, pick_ticks());
      write_reg(CSR_END_BIT_TICKS, ($urandom_range(2) == 0) ? 15'd0 : pick_ticks());
      write_reg(CSR_CUTOUT_TICKS, ($urandom_range(2) == 0) ? 15'd0 : pick_ticks());
      write_reg(CSR_CUTOUT_ENABLE, 15'($urandom_range(1)));
      write_reg(CSR_LEAD_ZERO_EN, 15'($urandom_range(1)));
      write_reg(CSR_FIRST_LEVEL, 15'($urandom_range(1)));
      write_reg(CSR_PREAMBLE_COUNT, preamble);
   endtask

   initial begin : stimulus
      int phase;
      int sent;
      int len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_ONE_BIT_TICKS;
      csr_wdata  = 15'd0;
      calm       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, a single-byte packet, then a multi-byte one.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain();

      // Cutout enabled but with zero ticks: no cutout symbols.
      write_reg(CSR_CUTOUT_ENABLE, 15'd1);
      send_byte(8'h01, 1'b1);
      drain();

      // Cutout on, leading zero, explicit end duration, inverted levels, longest ticks.
      write_reg(CSR_CUTOUT_TICKS, 15'h7FFF);
      write_reg(CSR_LEAD_ZERO_EN, 15'd1);
      write_reg(CSR_END_BIT_TICKS, 15'h7FFF);
      write_reg(CSR_FIRST_LEVEL, 15'd0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h7F, 1'b1);
      drain();

      // Preamble beyond the limit, with cutout taking room as well.
      write_reg(CSR_PREAMBLE_COUNT, 15'd63);
      send_byte(8'hC3, 1'b1);
      drain();

      // Longest legal preamble without cutout.
      write_reg(CSR_CUTOUT_ENABLE, 15'd0);
      write_reg(CSR_PREAMBLE_COUNT, 15'd48);
      send_byte(8'h3C, 1'b1);
      drain();

      // No preamble and zero bit durations.
      write_reg(CSR_PREAMBLE_COUNT, 15'd0);
      write_reg(CSR_ONE_BIT_TICKS, 15'd0);
      write_reg(CSR_ZERO_BIT_TICKS, 15'd0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h0F, 1'b1);
      drain();

      // Extreme one/zero split, end falls back to the one duration.
      write_reg(CSR_ONE_BIT_TICKS, 15'h7FFF);
      write_reg(CSR_ZERO_BIT_TICKS, 15'd1);
      write_reg(CSR_END_BIT_TICKS, 15'd0);
      write_reg(CSR_FIRST_LEVEL, 15'd1);
      write_reg(CSR_LEAD_ZERO_EN, 15'd0);
      write_reg(CSR_PREAMBLE_COUNT, 15'd10);
      send_byte(8'h96, 1'b1);
      drain();

      // Random phases: whole packets of random bytes under a fresh setting each time.
      for (phase = 0; phase < PHASES; phase++) begin
         calm = (phase == 2);
         randomise_regs();
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 5);
            send_packet(len);
            sent += len;
            // now and then hold the sender until the line has gone quiet
            if ($urandom_range(9) == 0)
               drain();
         end
         drain();
      end
      calm = 1'b0;

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
